@@ src/scb4_pkg.sv @@
// Shared constants, types and the alpha scaling function for the solid colour blender.
package scb4_pkg;

   localparam int unsigned LANES = 4;
   localparam int unsigned PIXEL_W = 32;
   localparam int unsigned COVER_W = 8;
   localparam int unsigned ALPHA_W = 8;
   localparam int unsigned SCALED_W = 15;
   localparam int unsigned WEIGHT_W = 14;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W = 32;

   // 505/1000 equals 101/200, and 5243/2^20 stands close enough to 1/200 that
   // the truncated product is exact for every 8-bit alpha.
   localparam logic [19:0] ALPHA_RECIP = 20'd529543;
   localparam int unsigned ALPHA_RECIP_SHIFT = 20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FILL_COLOR = 1'b0,
      REG_GLOBAL_ALPHA = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic s1_load;
      logic out_load;
   } pipe_ctrl_type;

   // s = alpha*64 + floor(505*alpha/1000)
   function automatic logic [SCALED_W-1:0] scale_alpha(input logic [ALPHA_W-1:0] alpha);
      logic [27:0] prod;
      logic [7:0] frac;
      prod = 28'(alpha) * 28'(ALPHA_RECIP);
      frac = prod[27:ALPHA_RECIP_SHIFT];
      return SCALED_W'({alpha, 6'b0}) + SCALED_W'(frac);
   endfunction

   localparam logic [SCALED_W-1:0] SCALED_ALPHA_RESET = 15'd16448;
   localparam logic [PIXEL_W-1:0] FILL_COLOR_RESET = 32'd0;

endpackage

@@ src/scb4_ctrl.sv @@
// Valid tracking and load enables for the two-stage blend pipeline.
module scb4_ctrl
   import scb4_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output pipe_ctrl_type ctrl
);

   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_en, s1_en;

   // A stage may load when it is empty or when its contents move on this cycle.
   assign out_en = !out_valid_ff || rsp_ready;
   assign s1_en = !s1_valid_ff || out_en;

   assign req_ready = s1_en;
   assign rsp_valid = out_valid_ff;

   assign ctrl.s1_load = s1_en;
   assign ctrl.out_load = out_en;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_en) begin
         out_valid_in = s1_valid_ff;
      end
      if (s1_en) begin
         s1_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTH
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted item did not reach the first stage");

   a_s1_moves_on: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_en |=> out_valid_ff)
      else $error("item in the first stage was lost on its way to the output");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && out_valid_ff && !rsp_ready))
      else $error("input stalled while the pipeline had room");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !out_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule

@@ src/scb4_lane.sv @@
// One pixel lane: coverage weight in the first stage, component blend and saturation in the second.
module scb4_lane
   import scb4_pkg::*;
(
   input  logic                clock,
   input  pipe_ctrl_type       ctrl,
   input  logic [PIXEL_W-1:0]  dest_pixel,
   input  logic [COVER_W-1:0]  coverage,
   input  logic [PIXEL_W-1:0]  fill_color,
   input  logic [SCALED_W-1:0] scaled_alpha,
   output logic [PIXEL_W-1:0]  blended_pixel
);

   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [PIXEL_W-1:0] dst_ff;
   logic [PIXEL_W-1:0] blended_ff, blended_in;
   logic [22:0] cover_prod;

   // w = (cover*256*s) >> 16, which is (cover*s) >> 8 and never exceeds 16383.
   assign cover_prod = 23'(coverage) * 23'(scaled_alpha);
   assign weight_in = cover_prod[21:8];

   always_comb begin
      logic signed [8:0] diff;
      logic signed [10:0] delta;
      logic signed [25:0] term;
      logic signed [9:0] shifted;
      logic signed [10:0] res;
      blended_in = '0;
      for (int k = 0; k < 4; k++) begin
         diff = $signed({1'b0, dst_ff[8*k +: 8]}) - $signed({1'b0, fill_color[8*k +: 8]});
         delta = $signed({diff, 2'b00});
         term = 26'(delta) * $signed({12'b0, weight_ff});
         // The arithmetic shift rounds toward minus infinity, as the blend requires.
         shifted = 10'(term >>> 16);
         res = $signed({3'b000, dst_ff[8*k +: 8]}) - 11'(shifted);
         if (res < 0) begin
            blended_in[8*k +: 8] = 8'd0;
         end else if (res > 11'sd255) begin
            blended_in[8*k +: 8] = 8'd255;
         end else begin
            blended_in[8*k +: 8] = res[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         weight_ff <= weight_in;
         dst_ff <= dest_pixel;
      end
      if (ctrl.out_load) begin
         blended_ff <= blended_in;
      end
   end

   assign blended_pixel = blended_ff;

endmodule

@@ src/solid_color_coverage_blend4.sv @@
// Top level of the solid colour blender: registers, four pixel lanes and the pipeline control.
//
//  channel   direction  handshake             payload
//  req       in         req_valid/req_ready   req_dest_pixel_0..3, req_cover_0..3
//  rsp       out        rsp_valid/rsp_ready   rsp_blended_pixel_0..3
//  csr       in         csr_wen               csr_index, csr_wdata
//
// One item per cycle enters while req_ready is high; its result is registered in the weight stage
// and then in the blend stage, both of which the four lanes run side by side.
// Reset clears the pipeline and sets fill_color to 0 and global_alpha to 255.
// While rsp_ready is low the pipeline holds; req_ready falls only once both stages are full.
module solid_color_coverage_blend4
   import scb4_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PIXEL_W-1:0]     req_dest_pixel_0,
   input  logic [PIXEL_W-1:0]     req_dest_pixel_1,
   input  logic [PIXEL_W-1:0]     req_dest_pixel_2,
   input  logic [PIXEL_W-1:0]     req_dest_pixel_3,
   input  logic [COVER_W-1:0]     req_cover_0,
   input  logic [COVER_W-1:0]     req_cover_1,
   input  logic [COVER_W-1:0]     req_cover_2,
   input  logic [COVER_W-1:0]     req_cover_3,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [PIXEL_W-1:0]     rsp_blended_pixel_0,
   output logic [PIXEL_W-1:0]     rsp_blended_pixel_1,
   output logic [PIXEL_W-1:0]     rsp_blended_pixel_2,
   output logic [PIXEL_W-1:0]     rsp_blended_pixel_3,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [PIXEL_W-1:0] fill_color_ff;
   // Only the scaled form of the alpha is kept; it is worked out as the register is written.
   logic [SCALED_W-1:0] scaled_alpha_ff;
   pipe_ctrl_type ctrl;

   logic [PIXEL_W-1:0] dest_pixel [LANES];
   logic [COVER_W-1:0] coverage [LANES];
   logic [PIXEL_W-1:0] blended [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= FILL_COLOR_RESET;
         scaled_alpha_ff <= SCALED_ALPHA_RESET;
      end else if (csr_wen) begin
         case (csr_reg_type'(csr_index))
            REG_FILL_COLOR: begin
               fill_color_ff <= csr_wdata[PIXEL_W-1:0];
            end
            REG_GLOBAL_ALPHA: begin
               scaled_alpha_ff <= scale_alpha(csr_wdata[ALPHA_W-1:0]);
            end
            default: begin
               fill_color_ff <= fill_color_ff;
            end
         endcase
      end
   end

   assign dest_pixel[0] = req_dest_pixel_0;
   assign dest_pixel[1] = req_dest_pixel_1;
   assign dest_pixel[2] = req_dest_pixel_2;
   assign dest_pixel[3] = req_dest_pixel_3;
   assign coverage[0] = req_cover_0;
   assign coverage[1] = req_cover_1;
   assign coverage[2] = req_cover_2;
   assign coverage[3] = req_cover_3;

   scb4_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl)
   );

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      scb4_lane u_lane (
         .clock         (clock),
         .ctrl          (ctrl),
         .dest_pixel    (dest_pixel[i]),
         .coverage      (coverage[i]),
         .fill_color    (fill_color_ff),
         .scaled_alpha  (scaled_alpha_ff),
         .blended_pixel (blended[i])
      );
   end

   assign rsp_blended_pixel_0 = blended[0];
   assign rsp_blended_pixel_1 = blended[1];
   assign rsp_blended_pixel_2 = blended[2];
   assign rsp_blended_pixel_3 = blended[3];

endmodule

@@ sim/tb_solid_color_coverage_blend4.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for solid_color_coverage_blend4 with a pixel blend predictor.
module tb_solid_color_coverage_blend4
   import scb4_pkg::*;
();

   localparam int RESET_CYCLES = 8;
   localparam int HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 170;
   localparam int PRESSURE_ITEMS = 80;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 8'hFF;

   typedef struct packed {
      logic [LANES-1:0][PIXEL_W-1:0] dest;
      logic [LANES-1:0][COVER_W-1:0] coverage;
   } span_item_type;

   typedef logic [LANES-1:0][PIXEL_W-1:0] span_pixels_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIXEL_W-1:0]     req_dest_pixel_0 = '0;
   logic [PIXEL_W-1:0]     req_dest_pixel_1 = '0;
   logic [PIXEL_W-1:0]     req_dest_pixel_2 = '0;
   logic [PIXEL_W-1:0]     req_dest_pixel_3 = '0;
   logic [COVER_W-1:0]     req_cover_0 = '0;
   logic [COVER_W-1:0]     req_cover_1 = '0;
   logic [COVER_W-1:0]     req_cover_2 = '0;
   logic [COVER_W-1:0]     req_cover_3 = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [PIXEL_W-1:0]     rsp_blended_pixel_0;
   logic [PIXEL_W-1:0]     rsp_blended_pixel_1;
   logic [PIXEL_W-1:0]     rsp_blended_pixel_2;
   logic [PIXEL_W-1:0]     rsp_blended_pixel_3;
   logic                   csr_wen = 1'b0;
   csr_reg_type            csr_index = REG_FILL_COLOR;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Copy of the block's registers as the predictor sees them.
   logic [PIXEL_W-1:0]     fill_rgb = FILL_COLOR_RESET;
   logic [ALPHA_W-1:0]     alpha_cfg = ALPHA_RESET;

   span_item_type          pending_items[$];
   span_pixels_type        blend_expected[$];
   span_item_type          offered_item = '0;
   span_pixels_type        seen_pixels;
   span_pixels_type        wanted_pixels;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   bit                     hold_on = 1'b0;
   int                     hold_count = 0;
   int                     error_count = 0;
   int                     cycle_count = 0;

   solid_color_coverage_blend4 dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_dest_pixel_0    (req_dest_pixel_0),
      .req_dest_pixel_1    (req_dest_pixel_1),
      .req_dest_pixel_2    (req_dest_pixel_2),
      .req_dest_pixel_3    (req_dest_pixel_3),
      .req_cover_0         (req_cover_0),
      .req_cover_1         (req_cover_1),
      .req_cover_2         (req_cover_2),
      .req_cover_3         (req_cover_3),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_blended_pixel_0 (rsp_blended_pixel_0),
      .rsp_blended_pixel_1 (rsp_blended_pixel_1),
      .rsp_blended_pixel_2 (rsp_blended_pixel_2),
      .rsp_blended_pixel_3 (rsp_blended_pixel_3),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Blends the fill colour into one destination pixel under the current registers.
   function automatic logic [PIXEL_W-1:0] blend_one(input logic [PIXEL_W-1:0] dst,
                                                    input logic [COVER_W-1:0] cov);
      int unsigned scaled;
      int unsigned weight;
      int diff;
      int term;
      int comp;
      logic [PIXEL_W-1:0] mixed;
      scaled = 32'(alpha_cfg) * 64 + (32'(alpha_cfg) * 505) / 1000;
      weight = ((32'(cov) << 8) * scaled) >> 16;
      mixed = '0;
      for (int k = 0; k < 4; k++) begin
         diff = (int'(dst[8*k +: 8]) - int'(fill_rgb[8*k +: 8])) * 4;
         term = diff * int'(weight);
         // The arithmetic shift floors negative terms, as the hardware does.
         comp = int'(dst[8*k +: 8]) - (term >>> 16);
         if (comp < 0) comp = 0;
         if (comp > 255) comp = 255;
         mixed[8*k +: 8] = comp[7:0];
      end
      return mixed;
   endfunction

   function automatic span_pixels_type blend_span(input span_item_type it);
      span_pixels_type px;
      for (int i = 0; i < LANES; i++) px[i] = blend_one(it.dest[i], it.coverage[i]);
      return px;
   endfunction

   // Byte values near the fill colour exercise the sign change of the blend term.
   function automatic logic [7:0] pick_byte(input logic [7:0] near);
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return near;
         3: return near + 8'd1;
         4: return near - 8'd1;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic span_item_type make_span_item();
      span_item_type it;
      for (int i = 0; i < LANES; i++) begin
         if ($urandom_range(3) == 0) begin
            it.dest[i] = $urandom;
         end else begin
            for (int k = 0; k < 4; k++) it.dest[i][8*k +: 8] = pick_byte(fill_rgb[8*k +: 8]);
         end
         case ($urandom_range(5))
            0: it.coverage[i] = 8'h00;
            1: it.coverage[i] = 8'hFF;
            default: it.coverage[i] = 8'($urandom);
         endcase
      end
      return it;
   endfunction

   // Covers are packed with byte i belonging to pixel i.
   task automatic add_span(input logic [PIXEL_W-1:0] d0, input logic [PIXEL_W-1:0] d1,
                           input logic [PIXEL_W-1:0] d2, input logic [PIXEL_W-1:0] d3,
                           input logic [31:0] covers);
      span_item_type it;
      it.dest = {d3, d2, d1, d0};
      it.coverage = covers;
      pending_items.push_back(it);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (idx == REG_FILL_COLOR) fill_rgb = data;
      else alpha_cfg = data[ALPHA_W-1:0];
   endtask

   task automatic wait_drained();
      while (pending_items.size() != 0 || blend_expected.size() != 0 || req_valid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) blend_expected.push_back(blend_span(offered_item));
         // An offered item stays on the bus untouched until it is taken.
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_dest_pixel_0 <= offered_item.dest[0];
               req_dest_pixel_1 <= offered_item.dest[1];
               req_dest_pixel_2 <= offered_item.dest[2];
               req_dest_pixel_3 <= offered_item.dest[3];
               req_cover_0 <= offered_item.coverage[0];
               req_cover_1 <= offered_item.coverage[1];
               req_cover_2 <= offered_item.coverage[2];
               req_cover_3 <= offered_item.coverage[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen_pixels = {rsp_blended_pixel_3, rsp_blended_pixel_2,
                           rsp_blended_pixel_1, rsp_blended_pixel_0};
            if (blend_expected.size() == 0) begin
               $display("%0t: result with no item outstanding, expected none, got %h",
                        $time, seen_pixels);
               error_count++;
            end else begin
               wanted_pixels = blend_expected.pop_front();
               for (int i = 0; i < LANES; i++) begin
                  if (seen_pixels[i] !== wanted_pixels[i]) begin
                     $display("%0t: blended_pixel_%0d expected %08h got %08h",
                              $time, i, wanted_pixels[i], seen_pixels[i]);
                     error_count++;
                  end
               end
            end
         end
         // A long hold-off lets the pipeline fill so that req_ready has to fall.
         if (hold_on && hold_count < HOLD_CYCLES) begin
            rsp_ready <= 1'b0;
            hold_count <= hold_count + 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
            if (!hold_on) hold_count <= 0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("** solid_color_coverage_blend4: FAILED **");
      $finish;
   end

   initial begin
      int left;
      int burst;
      logic [ALPHA_W-1:0] alpha_pick [PHASE_COUNT];
      alpha_pick = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'($urandom), 8'd255, 8'($urandom)};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed items, first with the registers as reset leaves them.
      add_span(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_span(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      add_span(32'h80FF_007F, 32'h0102_0304, 32'hFEFD_FCFB, 32'h7F80_8180, 32'h0000_0000);
      add_span(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'hC3B4_A596, 32'hFF80_0100);
      add_span(32'h0000_0001, 32'hFF00_00FF, 32'h0101_0101, 32'hFEFE_FEFE, 32'h407F_FE02);
      wait_drained();
      write_reg(REG_FILL_COLOR, 32'hFFFF_FFFF);
      @(negedge clock);
      add_span(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
      add_span(32'hFF00_FF00, 32'h00FF_00FF, 32'h8080_8080, 32'h7F7F_7F7F, 32'h01FE_7F80);
      add_span(32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0000, 32'h5555_AAAA, 32'hFFFF_FFFF);
      wait_drained();
      // Zero opacity: the upper data bits have to be dropped by the register.
      write_reg(REG_FILL_COLOR, 32'h807F_01FE);
      write_reg(REG_GLOBAL_ALPHA, 32'hA5A5_A500);
      @(negedge clock);
      add_span(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h807F_01FE, 32'hFFFF_FFFF);
      add_span(32'hDEAD_BEEF, 32'h0F0F_F0F0, 32'h0000_00FF, 32'hFF00_0000, 32'h8001_FF7F);
      wait_drained();
      write_reg(REG_GLOBAL_ALPHA, 32'h5A5A_5A01);
      @(negedge clock);
      add_span(32'h0000_0000, 32'hFFFF_FFFF, 32'h7F80_017E, 32'h00FF_FF00, 32'hFFFF_FFFF);
      wait_drained();

      // Receiver holds off for a long stretch while the sender keeps offering.
      write_reg(REG_FILL_COLOR, $urandom);
      write_reg(REG_GLOBAL_ALPHA, {24'($urandom), 8'hFF});
      @(negedge clock);
      send_idle_pct = 0;
      stall_pct = 0;
      hold_on = 1'b1;
      repeat (PRESSURE_ITEMS) pending_items.push_back(make_span_item());
      wait_drained();
      hold_on = 1'b0;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_reg(REG_FILL_COLOR, (p == 0) ? 32'h0000_0000 :
                                   (p == 1) ? 32'hFFFF_FFFF : 32'($urandom));
         write_reg(REG_GLOBAL_ALPHA, {24'($urandom), alpha_pick[p]});
         @(negedge clock);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 85; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 14; stall_pct = 14; end
         endcase
         left = PHASE_ITEMS;
         while (left > 0) begin
            burst = $urandom_range(60, 10);
            if (burst > left) burst = left;
            repeat (burst) pending_items.push_back(make_span_item());
            left -= burst;
            // Now and then the sender pauses until every result is back.
            if ($urandom_range(3) == 0) begin
               wait_drained();
            end else begin
               while (pending_items.size() != 0) @(negedge clock);
            end
         end
         wait_drained();
      end

      repeat (6) @(posedge clock);
      if (error_count == 0) begin
         $display("** solid_color_coverage_blend4: PASSED **");
      end else begin
         $display("** solid_color_coverage_blend4: FAILED **");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/scb4_pkg.sv
src/scb4_ctrl.sv
src/scb4_lane.sv
src/solid_color_coverage_blend4.sv
sim/tb_solid_color_coverage_blend4.sv
